// ===== hw/rtl/m3vd_pkg.sv =====
// shared types, widths and saturation helpers for the 3x3 transform block
// no dependencies; every rtl file of the block imports this package
package m3vd_pkg;

    localparam int DATA_W  = 16;
    localparam int FRAC    = 8;
    localparam int DET_OUT_W = 2 * DATA_W;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int COF_W   = PROD_W + 1;
    localparam int DPROD_W = DATA_W + COF_W;
    localparam int DET_W   = DPROD_W + 2;
    localparam int DOT_SH_W = DOT_W - FRAC;
    localparam int DET_SH_W = DET_W - FRAC;

    localparam logic signed [DOT_SH_W-1:0] DOT_HI =
        DOT_SH_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    localparam logic signed [DOT_SH_W-1:0] DOT_LO = -DOT_HI - DOT_SH_W'(1);
    localparam logic signed [DET_SH_W-1:0] DET_HI =
        DET_SH_W'((64'sd1 <<< (DET_OUT_W - 1)) - 64'sd1);
    localparam logic signed [DET_SH_W-1:0] DET_LO = -DET_HI - DET_SH_W'(1);

    typedef struct packed {
        logic signed [DATA_W-1:0] m_r0_c0;
        logic signed [DATA_W-1:0] m_r1_c0;
        logic signed [DATA_W-1:0] m_r2_c0;
        logic signed [DATA_W-1:0] m_r0_c1;
        logic signed [DATA_W-1:0] m_r1_c1;
        logic signed [DATA_W-1:0] m_r2_c1;
        logic signed [DATA_W-1:0] m_r0_c2;
        logic signed [DATA_W-1:0] m_r1_c2;
        logic signed [DATA_W-1:0] m_r2_c2;
        logic signed [DATA_W-1:0] v_x;
        logic signed [DATA_W-1:0] v_y;
        logic signed [DATA_W-1:0] v_z;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]    out_x;
        logic signed [DATA_W-1:0]    out_y;
        logic signed [DATA_W-1:0]    out_z;
        logic signed [DET_OUT_W-1:0] det_value;
        logic                        saturated;
    } res_t;

    // stage 1: raw products; cp holds the six 2x2 minor terms of rows 1 and 2
    typedef struct packed {
        logic [2:0][2:0][PROD_W-1:0] dp;
        logic [5:0][PROD_W-1:0]      cp;
        logic [2:0][DATA_W-1:0]      row0;
    } s1_t;

    typedef struct packed {
        logic [2:0][DOT_W-1:0]  dot;
        logic [2:0][COF_W-1:0]  cof;
        logic [2:0][DATA_W-1:0] row0;
    } s2_t;

    typedef struct packed {
        logic [2:0][DOT_W-1:0]   dot;
        logic [2:0][DPROD_W-1:0] dp;
    } s3_t;

    typedef struct packed {
        logic [2:0][DOT_W-1:0] dot;
        logic [DET_W-1:0]      det;
    } s4_t;

    typedef struct packed {
        logic                     clip;
        logic signed [DATA_W-1:0] val;
    } sat_data_t;

    typedef struct packed {
        logic                        clip;
        logic signed [DET_OUT_W-1:0] val;
    } sat_det_t;

    function automatic sat_data_t sat_data(input logic signed [DOT_SH_W-1:0] x);
        sat_data_t r;
        if (x > DOT_HI)
        begin
            r.clip = 1'b1;
            r.val  = DOT_HI[DATA_W-1:0];
        end
        else if (x < DOT_LO)
        begin
            r.clip = 1'b1;
            r.val  = DOT_LO[DATA_W-1:0];
        end
        else
        begin
            r.clip = 1'b0;
            r.val  = x[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic sat_det_t sat_det(input logic signed [DET_SH_W-1:0] x);
        sat_det_t r;
        if (x > DET_HI)
        begin
            r.clip = 1'b1;
            r.val  = DET_HI[DET_OUT_W-1:0];
        end
        else if (x < DET_LO)
        begin
            r.clip = 1'b1;
            r.val  = DET_LO[DET_OUT_W-1:0];
        end
        else
        begin
            r.clip = 1'b0;
            r.val  = x[DET_OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/mat3_vector_transform_and_determinant.sv =====
// top level of the 3x3 matrix-vector transform and determinant pipeline
// depends on m3vd_pkg and the four m3vd stage modules
//
// usage
// - a request is a 3x3 matrix and a 3-vector, all signed q8.8, packed in
//   the request struct; it is taken at a rising edge with start high and
//   busy low
// - busy never rises: the pipeline advances every cycle, so a new request
//   may be issued in every cycle (one item per cycle sustained)
// - each request yields one result: m*v as three q8.8 values and det(m) as
//   q16.16, all floor-shifted and saturated, plus a saturated flag
// - the result sits on the result port for exactly one cycle with done high;
//   the receiver takes it at the edge that ends that cycle
// - a request passes through five register stages: products, row sums and
//   cofactors, row 0 times cofactors, determinant sum, shift and saturate
// - the receiver cannot hold results off, so there is no stall path;
//   results leave in request order
// - rst_n clears only the stage valid bits; requests in flight are dropped
//   and done stays low until new requests come through
module mat3_vector_transform_and_determinant (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  m3vd_pkg::req_t  request,
    output logic            done,
    output m3vd_pkg::res_t  result
);
    import m3vd_pkg::*;

    logic accept;
    logic s1_valid;
    logic s2_valid;
    logic s4_valid;
    s1_t  s1_data;
    s2_t  s2_data;
    s4_t  s4_data;

    // pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage 1: fifteen parallel 16x16 products
    m3vd_mul_stage u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .data_in   (request),
        .valid_out (s1_valid),
        .data_out  (s1_data)
    );

    // stage 2: dot sums and 2x2 minors
    m3vd_sum_stage u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid),
        .data_in   (s1_data),
        .valid_out (s2_valid),
        .data_out  (s2_data)
    );

    // stages 3 and 4: cofactor expansion along row 0
    m3vd_det_stage u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s2_valid),
        .data_in   (s2_data),
        .valid_out (s4_valid),
        .data_out  (s4_data)
    );

    // stage 5: scaling, clipping, result register
    m3vd_sat_stage u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s4_valid),
        .data_in   (s4_data),
        .valid_out (done),
        .data_out  (result)
    );

    // a taken request always reaches the first stage register
    a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid)
        else $error("accepted request lost before stage 1");

    // valid travels from the sums to the determinant stages without a gap
    a_s2_to_s4: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid |=> ##1 s4_valid)
        else $error("request lost in determinant stages");

    // every result strobe comes from a valid stage 4 item
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s4_valid))
        else $error("result strobe without a request behind it");

endmodule

// ===== hw/rtl/m3vd_mul_stage.sv =====
// first pipeline stage: all 16x16 products for the dot rows and the minors
// depends on m3vd_pkg
module m3vd_mul_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid_in,
    input  m3vd_pkg::req_t  data_in,
    output logic            valid_out,
    output m3vd_pkg::s1_t   data_out
);
    import m3vd_pkg::*;

    logic signed [DATA_W-1:0] mat [3][3];
    logic signed [DATA_W-1:0] vec [3];
    logic signed [PROD_W-1:0] prod;
    s1_t  s1_next;
    s1_t  s1_reg;
    logic valid_reg;

    always_comb
    begin
        mat[0][0] = data_in.m_r0_c0;
        mat[1][0] = data_in.m_r1_c0;
        mat[2][0] = data_in.m_r2_c0;
        mat[0][1] = data_in.m_r0_c1;
        mat[1][1] = data_in.m_r1_c1;
        mat[2][1] = data_in.m_r2_c1;
        mat[0][2] = data_in.m_r0_c2;
        mat[1][2] = data_in.m_r1_c2;
        mat[2][2] = data_in.m_r2_c2;
        vec[0]    = data_in.v_x;
        vec[1]    = data_in.v_y;
        vec[2]    = data_in.v_z;
    end

    always_comb
    begin
        prod = '0;
        s1_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod = mat[r][c] * vec[c];
                s1_next.dp[r][c] = prod;
            end
            s1_next.row0[r] = mat[0][r];
        end
        s1_next.cp[0] = mat[1][1] * mat[2][2];
        s1_next.cp[1] = mat[2][1] * mat[1][2];
        s1_next.cp[2] = mat[1][0] * mat[2][2];
        s1_next.cp[3] = mat[2][0] * mat[1][2];
        s1_next.cp[4] = mat[1][0] * mat[2][1];
        s1_next.cp[5] = mat[2][0] * mat[1][1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = s1_reg;

endmodule

// ===== hw/rtl/m3vd_sum_stage.sv =====
// second pipeline stage: dot row sums and the three row 0 cofactors
// depends on m3vd_pkg
module m3vd_sum_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid_in,
    input  m3vd_pkg::s1_t  data_in,
    output logic           valid_out,
    output m3vd_pkg::s2_t  data_out
);
    import m3vd_pkg::*;

    s2_t  s2_next;
    s2_t  s2_reg;
    logic valid_reg;

    always_comb
    begin
        s2_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            s2_next.dot[r] = DOT_W'($signed(data_in.dp[r][0]))
                           + DOT_W'($signed(data_in.dp[r][1]))
                           + DOT_W'($signed(data_in.dp[r][2]));
            s2_next.cof[r] = COF_W'($signed(data_in.cp[2*r]))
                           - COF_W'($signed(data_in.cp[2*r+1]));
        end
        s2_next.row0 = data_in.row0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = s2_reg;

endmodule

// ===== hw/rtl/m3vd_det_stage.sv =====
// third and fourth pipeline stages: row 0 times cofactors, then the signed sum
// depends on m3vd_pkg; dot sums ride along unchanged
module m3vd_det_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid_in,
    input  m3vd_pkg::s2_t  data_in,
    output logic           valid_out,
    output m3vd_pkg::s4_t  data_out
);
    import m3vd_pkg::*;

    s3_t  s3_next;
    s3_t  s3_reg;
    s4_t  s4_next;
    s4_t  s4_reg;
    logic signed [DPROD_W-1:0] dprod;
    logic valid3_reg;
    logic valid4_reg;

    always_comb
    begin
        dprod = '0;
        s3_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            dprod = $signed(data_in.row0[k]) * $signed(data_in.cof[k]);
            s3_next.dp[k] = dprod;
        end
        s3_next.dot = data_in.dot;
    end

    always_comb
    begin
        s4_next.dot = s3_reg.dot;
        s4_next.det = DET_W'($signed(s3_reg.dp[0]))
                    - DET_W'($signed(s3_reg.dp[1]))
                    + DET_W'($signed(s3_reg.dp[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            valid3_reg <= valid_in;
            valid4_reg <= valid3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_reg <= s3_next;
        s4_reg <= s4_next;
    end

    assign valid_out = valid4_reg;
    assign data_out  = s4_reg;

endmodule

// ===== hw/rtl/m3vd_sat_stage.sv =====
// last pipeline stage: floor shift, saturation and the result register
// depends on m3vd_pkg
module m3vd_sat_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid_in,
    input  m3vd_pkg::s4_t  data_in,
    output logic           valid_out,
    output m3vd_pkg::res_t data_out
);
    import m3vd_pkg::*;

    logic signed [DOT_W-1:0] dot_sh [3];
    logic signed [DET_W-1:0] det_sh;
    sat_data_t dot_sat [3];
    sat_det_t  det_sat;
    res_t res_next;
    res_t res_reg;
    logic valid_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            dot_sh[r]  = $signed(data_in.dot[r]) >>> FRAC;
            dot_sat[r] = sat_data(dot_sh[r][DOT_SH_W-1:0]);
        end
        det_sh  = $signed(data_in.det) >>> FRAC;
        det_sat = sat_det(det_sh[DET_SH_W-1:0]);
        res_next.out_x     = dot_sat[0].val;
        res_next.out_y     = dot_sat[1].val;
        res_next.out_z     = dot_sat[2].val;
        res_next.det_value = det_sat.val;
        res_next.saturated = dot_sat[0].clip | dot_sat[1].clip
                           | dot_sat[2].clip | det_sat.clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = res_reg;

endmodule

// ===== tb/tb.sv =====
// self-checking bench for the 3x3 matrix-vector transform and determinant pipeline
// depends on m3vd_pkg and mat3_vector_transform_and_determinant; drives requests
// from a queue, predicts each result in fixed point and checks it on done
`timescale 1ns / 1ps

module tb;

    import m3vd_pkg::*;

    // random requests after the directed set
    localparam int RANDOM_JOBS    = 1250;
    // the last requests go in back to back, no idle bursts
    localparam int TAIL_JOBS      = 120;
    // cycles with no request taken and no result seen before we give up
    localparam int WATCHDOG_LIMIT = 200;
    // margin after the last expected result, to catch stray results at the end
    localparam int DRAIN_CYCLES   = 12;

    logic  clk   = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    req_t  request = '0;
    logic  done;
    res_t  result;

    req_t  matrix_jobs[$];
    res_t  predicted_results[$];
    int    gap_left     = 0;
    int    quiet_cycles = 0;
    int    mismatches   = 0;

    mat3_vector_transform_and_determinant DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #1 clk = ~clk;

    // clip a full-precision value to a signed w-bit range, flag if clipped
    function automatic longint saturate(longint x, int unsigned w, inout logic clip);
        longint top;
        longint bottom;
        top    = (64'sd1 <<< (w - 1)) - 64'sd1;
        bottom = -top - 64'sd1;
        if (x > top)
        begin
            clip = 1'b1;
            return top;
        end
        if (x < bottom)
        begin
            clip = 1'b1;
            return bottom;
        end
        return x;
    endfunction

    // expected result: m*v in q8.8 and det(m) in q16.16, floor-shifted and saturated
    // 64 bits are plenty: the widest sum (determinant) needs about 51 bits
    function automatic res_t transform_of(req_t q);
        longint m[3][3];
        longint v[3];
        longint dots[3];
        longint minor0;
        longint minor1;
        longint minor2;
        longint det;
        logic   clip;
        res_t   r;
        m[0][0] = q.m_r0_c0;  m[0][1] = q.m_r0_c1;  m[0][2] = q.m_r0_c2;
        m[1][0] = q.m_r1_c0;  m[1][1] = q.m_r1_c1;  m[1][2] = q.m_r1_c2;
        m[2][0] = q.m_r2_c0;  m[2][1] = q.m_r2_c1;  m[2][2] = q.m_r2_c2;
        v[0] = q.v_x;
        v[1] = q.v_y;
        v[2] = q.v_z;
        clip = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            dots[i] = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
            dots[i] = saturate(dots[i] >>> FRAC, DATA_W, clip);
        end
        // cofactor expansion along row 0
        minor0 = m[1][1] * m[2][2] - m[2][1] * m[1][2];
        minor1 = m[1][0] * m[2][2] - m[2][0] * m[1][2];
        minor2 = m[1][0] * m[2][1] - m[2][0] * m[1][1];
        det    = m[0][0] * minor0 - m[0][1] * minor1 + m[0][2] * minor2;
        det    = saturate(det >>> FRAC, DET_OUT_W, clip);
        r.out_x     = DATA_W'(dots[0]);
        r.out_y     = DATA_W'(dots[1]);
        r.out_z     = DATA_W'(dots[2]);
        r.det_value = DET_OUT_W'(det);
        r.saturated = clip;
        return r;
    endfunction

    // request from a row-major matrix and a vector
    function automatic req_t mat_req(int a00, int a01, int a02,
                                     int a10, int a11, int a12,
                                     int a20, int a21, int a22,
                                     int x, int y, int z);
        req_t q;
        q.m_r0_c0 = DATA_W'(a00);  q.m_r0_c1 = DATA_W'(a01);  q.m_r0_c2 = DATA_W'(a02);
        q.m_r1_c0 = DATA_W'(a10);  q.m_r1_c1 = DATA_W'(a11);  q.m_r1_c2 = DATA_W'(a12);
        q.m_r2_c0 = DATA_W'(a20);  q.m_r2_c1 = DATA_W'(a21);  q.m_r2_c2 = DATA_W'(a22);
        q.v_x = DATA_W'(x);
        q.v_y = DATA_W'(y);
        q.v_z = DATA_W'(z);
        return q;
    endfunction

    // random word, arithmetic-shifted down to spread the magnitudes
    function automatic logic signed [DATA_W-1:0] random_field(int unsigned sh);
        return $signed(DATA_W'($urandom)) >>> sh;
    endfunction

    // one shift for the whole request, or a fresh shift per field
    function automatic req_t random_req(int unsigned sh, bit per_field);
        logic [11:0][DATA_W-1:0] words;
        for (int i = 0; i < 12; i++)
            words[i] = random_field(per_field ? $urandom_range(0, 15) : sh);
        return req_t'(words);
    endfunction

    task automatic check_field(string name, logic signed [63:0] exp_val,
                               logic signed [63:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // driver: one request per cycle from the job queue, with random idle bursts
    // a request is taken at an edge with start high and busy low
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                predicted_results.push_back(transform_of(request));
            // hold the current request while busy; it never rises, but honor it
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    start <= 1'b0;
                    gap_left--;
                end
                else if (matrix_jobs.size() == 0)
                    start <= 1'b0;
                else if (matrix_jobs.size() > TAIL_JOBS
                         && (matrix_jobs.size() / 160) % 3 != 0
                         && $urandom_range(0, 3) == 0)
                begin
                    // idle burst, this cycle included; gap_left holds the idle cycles still to come
                    start    <= 1'b0;
                    gap_left = $urandom_range(0, 8);
                end
                else
                begin
                    request <= matrix_jobs.pop_front();
                    start   <= 1'b1;
                end
            end
        end
    end

    // monitor: done marks a one-cycle result, always taken; compare with the oldest prediction
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("result with no request pending: x=%0d y=%0d z=%0d det=%0d",
                       result.out_x, result.out_y, result.out_z, result.det_value);
                mismatches++;
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("out_x", want.out_x, result.out_x);
                check_field("out_y", want.out_y, result.out_y);
                check_field("out_z", want.out_z, result.out_z);
                check_field("det_value", want.det_value, result.det_value);
                check_field("saturated", {63'd0, want.saturated}, {63'd0, result.saturated});
            end
        end
    end

    // watchdog: counts cycles with neither a request taken nor a result seen
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        req_t        base;
        int unsigned sh;
        int          kind;
        int          queued;

        // all zero, then all extremes: dot sums saturate both ways
        matrix_jobs.push_back(mat_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        matrix_jobs.push_back(mat_req(32767, 32767, 32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767, 32767, 32767));
        matrix_jobs.push_back(mat_req(-32768, -32768, -32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768, -32768, -32768));
        matrix_jobs.push_back(mat_req(32767, 32767, 32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, -32768, -32768, -32768));
        // identity passes the vector through unchanged
        matrix_jobs.push_back(mat_req(256, 0, 0, 0, 256, 0, 0, 0, 256, 32767, -32768, 1));
        // dot exactly at the top vs one step over; determinant clips high
        matrix_jobs.push_back(mat_req(32767, 0, 0, 0, 32767, 0, 0, 0, 32767, 256, 257, 0));
        // dot exactly at the bottom; determinant clips low
        matrix_jobs.push_back(mat_req(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768, 256, 0, 0));
        // floor shift: small negatives round toward minus infinity
        matrix_jobs.push_back(mat_req(1, 0, 0, 0, 1, 0, 0, 0, 1, -1, 1, -255));
        matrix_jobs.push_back(mat_req(-1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0));
        // determinant around the 32-bit edges
        matrix_jobs.push_back(mat_req(8192, 0, 0, 0, 8192, 0, 0, 0, 8191, 0, 0, 0));
        matrix_jobs.push_back(mat_req(8192, 0, 0, 0, 8192, 0, 0, 0, 8192, 0, 0, 0));
        matrix_jobs.push_back(mat_req(-8192, 0, 0, 0, 8192, 0, 0, 0, 8192, 0, 0, 0));
        matrix_jobs.push_back(mat_req(-8192, 0, 0, 0, 8192, 0, 0, 0, 8193, 0, 0, 0));
        // full matrix exercises all cofactor signs, det = -3.0
        matrix_jobs.push_back(mat_req(256, 512, 768, 1024, 1280, 1536, 1792, 2048, 2560,
                                      256, -512, 768));
        // odd permutation, det = -1.0
        matrix_jobs.push_back(mat_req(0, 256, 0, 256, 0, 0, 0, 0, 256, 100, -200, 300));
        // matrix-matrix product: one matrix, each column of the right operand as vector
        base = random_req(6, 1'b0);
        for (int col = 0; col < 3; col++)
        begin
            base.v_x = random_field(6);
            base.v_y = random_field(6);
            base.v_z = random_field(6);
            matrix_jobs.push_back(base);
        end

        // random part: full range, scaled, mixed scales and column-wise products
        queued = 0;
        while (queued < RANDOM_JOBS)
        begin
            kind = $urandom_range(0, 9);
            sh   = $urandom_range(0, 15);
            if (kind < 3)
            begin
                matrix_jobs.push_back(random_req(0, 1'b0));
                queued++;
            end
            else if (kind < 7)
            begin
                matrix_jobs.push_back(random_req(sh, 1'b0));
                queued++;
            end
            else if (kind < 9)
            begin
                matrix_jobs.push_back(random_req(0, 1'b1));
                queued++;
            end
            else
            begin
                base = random_req(sh, 1'b0);
                for (int col = 0; col < 3; col++)
                begin
                    base.v_x = random_field(sh);
                    base.v_y = random_field(sh);
                    base.v_z = random_field(sh);
                    matrix_jobs.push_back(base);
                end
                queued += 3;
            end
        end

        // reset held low from time zero, released once
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // wait until every request is taken, then until every result is back
        while (matrix_jobs.size() != 0 || start)
            @(negedge clk);
        while (predicted_results.size() != 0)
            @(negedge clk);
        // any late result would be flagged by the monitor here
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
